// ===== rtl/mmhb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mmhb_pkg
// Shared codes, reset constants and types for the min/max histogram binner.
// ----------------------------------------------------------------------------
package mmhb_pkg;

    localparam logic [1:0] OP_LOAD     = 2'd0;
    localparam logic [1:0] OP_CLASSIFY = 2'd1;
    localparam logic [1:0] OP_RESTART  = 2'd2;

    localparam int NUM_BINS_RESET = 16;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage
`default_nettype wire

// ===== rtl/mmhb_ifs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mmhb interfaces
// Valid/ready channels for items, results and the bin count register.
// ----------------------------------------------------------------------------
interface mmhb_item_if #(
    parameter int VALUE_BITS = 16,
    parameter int INDEX_BITS = 10
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   op;
    logic signed [VALUE_BITS-1:0] value;
    logic [INDEX_BITS-1:0]        point_index;

    modport source (output valid, output op, output value, output point_index, input ready);
    modport sink   (input valid, input op, input value, input point_index, output ready);
endinterface

interface mmhb_result_if #(
    parameter int INDEX_BITS = 10,
    parameter int BIN_BITS   = 8
);
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] echo_index;
    logic [BIN_BITS-1:0]   bin_index;
    logic                  error;

    modport source (output valid, output echo_index, output bin_index, output error,
                    input ready);
    modport sink   (input valid, input echo_index, input bin_index, input error,
                    output ready);
endinterface

interface mmhb_cfg_if #(
    parameter int BINS_BITS = 9
);
    logic                 valid;
    logic                 ready;
    logic [BINS_BITS-1:0] num_bins;

    modport source (output valid, output num_bins, input ready);
    modport sink   (input valid, input num_bins, output ready);
endinterface
`default_nettype wire

// ===== rtl/min_max_histogram_binner.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// min_max_histogram_binner
// Loads points into a value store, tracks their minimum and maximum and
// returns the equal-width histogram bin of a stored point.
//
//   channel  dir  fields                               transfer
//   item     in   op, value, point_index               valid & ready
//   result   out  echo_index, bin_index, error         valid & ready
//   cfg      in   num_bins                             valid & ready
//
// Classify steps through accept, store read, multiply, divider start plus
// one quotient bit per cycle, then the result register. Unloaded indices
// and a zero range skip the divider. Reset clears the count and the
// extremes at once; the store holds no reset. A stalled result waits in its
// register while loads and restarts are still taken.
// ----------------------------------------------------------------------------
module min_max_histogram_binner #(
    parameter int MAX_POINTS = 1024,
    parameter int MAX_BINS   = 256,
    parameter int VALUE_BITS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    mmhb_item_if.sink     item,
    mmhb_result_if.source result,
    mmhb_cfg_if.sink      cfg
);
    import mmhb_pkg::*;

    localparam int IW       = $clog2(MAX_POINTS);
    localparam int CW       = $clog2(MAX_POINTS + 1);
    localparam int BW       = $clog2(MAX_BINS);
    localparam int NW       = BW + 1;
    localparam int PW       = VALUE_BITS + NW;
    localparam int NB_RESET = (NUM_BINS_RESET > MAX_BINS) ? MAX_BINS : NUM_BINS_RESET;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_DIV,
        S_OUT
    } state_t;

    state_t                       state_reg;
    state_t                       state_next;
    logic signed [VALUE_BITS-1:0] min_reg;
    logic signed [VALUE_BITS-1:0] max_reg;
    logic [CW-1:0]                count_reg;
    logic [NW-1:0]                num_bins_reg;
    logic [IW-1:0]                idx_reg;
    logic                         err_reg;
    logic                         skip_reg;
    logic [VALUE_BITS-1:0]        diff_reg;
    logic [VALUE_BITS-1:0]        range_reg;
    logic                         res_valid_reg;
    logic [IW-1:0]                res_idx_reg;
    logic [BW-1:0]                res_bin_reg;
    logic                         res_err_reg;

    logic                         item_xfer;
    logic                         do_load;
    logic                         do_classify;
    logic                         out_load;
    logic [NW-1:0]                bins_eff;
    logic signed [VALUE_BITS-1:0] rd_data;
    logic signed [VALUE_BITS:0]   diff_full;
    logic signed [VALUE_BITS:0]   range_full;
    logic [PW-1:0]                product;
    logic                         div_start;
    logic [NW-1:0]                div_q;
    div_stat_t                    div_stat;
    logic [NW-1:0]                bin_clamped;

    assign item.ready  = (state_reg == S_IDLE);
    assign cfg.ready   = 1'b1;
    assign item_xfer   = item.valid && item.ready;
    assign do_load     = item_xfer && (item.op == OP_LOAD) && (count_reg < CW'(MAX_POINTS));
    assign do_classify = item_xfer && (item.op == OP_CLASSIFY);

    always_comb
    begin
        if (num_bins_reg == '0)
        begin
            bins_eff = NW'(1);
        end
        else if (num_bins_reg > NW'(MAX_BINS))
        begin
            bins_eff = NW'(MAX_BINS);
        end
        else
        begin
            bins_eff = num_bins_reg;
        end
    end

    mmhb_value_ram #(
        .DEPTH (MAX_POINTS),
        .WIDTH (VALUE_BITS),
        .AW    (IW)
    ) u_ram (
        .clk   (clk),
        .we    (do_load),
        .waddr (count_reg[IW-1:0]),
        .wdata (item.value),
        .re    (do_classify),
        .raddr (item.point_index),
        .rdata (rd_data)
    );

    assign diff_full  = (VALUE_BITS+1)'(rd_data) - (VALUE_BITS+1)'(min_reg);
    assign range_full = (VALUE_BITS+1)'(max_reg) - (VALUE_BITS+1)'(min_reg);
    assign product    = PW'(diff_reg) * PW'(bins_eff);
    assign div_start  = (state_reg == S_MUL);

    mmhb_divider #(
        .DEN_W (VALUE_BITS),
        .QUO_W (NW),
        .NUM_W (PW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (product),
        .denom    (range_reg),
        .quotient (div_q),
        .stat     (div_stat)
    );

    assign bin_clamped = (div_q > bins_eff - 1'b1) ? (bins_eff - 1'b1) : div_q;
    assign out_load    = (state_reg == S_OUT) && (!res_valid_reg || result.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (do_classify)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = (err_reg || (range_full == '0)) ? S_OUT : S_MUL;
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            min_reg       <= {1'b0, {(VALUE_BITS-1){1'b1}}};
            max_reg       <= {1'b1, {(VALUE_BITS-1){1'b0}}};
            count_reg     <= '0;
            num_bins_reg  <= NW'(NB_RESET);
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid && cfg.ready)
            begin
                num_bins_reg <= cfg.num_bins;
            end

            if (do_load)
            begin
                count_reg <= count_reg + 1'b1;
                if (item.value < min_reg)
                begin
                    min_reg <= item.value;
                end
                if (item.value > max_reg)
                begin
                    max_reg <= item.value;
                end
            end
            else if (item_xfer && (item.op == OP_RESTART))
            begin
                min_reg   <= {1'b0, {(VALUE_BITS-1){1'b1}}};
                max_reg   <= {1'b1, {(VALUE_BITS-1){1'b0}}};
                count_reg <= '0;
            end

            if (do_classify)
            begin
                idx_reg <= item.point_index;
                err_reg <= (CW'(item.point_index) >= count_reg);
            end

            if (state_reg == S_READ)
            begin
                diff_reg  <= diff_full[VALUE_BITS-1:0];
                range_reg <= range_full[VALUE_BITS-1:0];
                skip_reg  <= err_reg || (range_full == '0);
            end

            if (out_load)
            begin
                res_valid_reg <= 1'b1;
                res_idx_reg   <= idx_reg;
                res_err_reg   <= err_reg;
                res_bin_reg   <= skip_reg ? '0 : bin_clamped[BW-1:0];
            end
            else if (result.valid && result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid      = res_valid_reg;
    assign result.echo_index = res_idx_reg;
    assign result.bin_index  = res_bin_reg;
    assign result.error      = res_err_reg;

    a_err_bin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.error |-> result.bin_index == '0)
        else $error("error result carries a non-zero bin");

    a_bin_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> NW'(result.bin_index) < bins_eff)
        else $error("bin index beyond bin count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_POINTS))
        else $error("point count beyond capacity");

    a_load_counts: assert property (@(posedge clk) disable iff (!rst_n)
        do_load |=> count_reg == $past(count_reg) + 1'b1)
        else $error("load did not advance the point count");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide state");

endmodule
`default_nettype wire

// ===== rtl/mmhb_value_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mmhb_value_ram
// Point value store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mmhb_value_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16,
    parameter int AW    = 10
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== rtl/mmhb_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mmhb_divider
// Restoring divider, one quotient bit per cycle; quotient below 2**QUO_W.
// ----------------------------------------------------------------------------
module mmhb_divider #(
    parameter int DEN_W = 16,
    parameter int QUO_W = 9,
    parameter int NUM_W = DEN_W + QUO_W
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] numer,
    input  wire logic [DEN_W-1:0] denom,
    output logic      [QUO_W-1:0] quotient,
    output mmhb_pkg::div_stat_t   stat
);
    import mmhb_pkg::*;

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [NUM_W-1:0] rem_reg;
    logic [NUM_W-1:0] dsh_reg;
    logic [QUO_W-1:0] q_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             fits;

    assign fits = (rem_reg >= dsh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= numer;
                dsh_reg  <= NUM_W'({denom, {(QUO_W-1){1'b0}}});
                q_reg    <= '0;
                cnt_reg  <= CNT_W'(QUO_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (fits)
                begin
                    rem_reg <= rem_reg - dsh_reg;
                end
                q_reg   <= {q_reg[QUO_W-2:0], fits};
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient  = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
`default_nettype wire
